FILE: hw/rtl/vpv_pkg.sv
// vpv_pkg: shared types, widths and codes of the vertex projection viewport core
// used by every module under hw/rtl; depends on nothing
`timescale 1ns / 1ps

package vpv_pkg;

    // number formats
    localparam int MATRIX_FRAC_BITS = 11;
    localparam int COORD_FRAC_BITS  = 16;
    localparam int COORD_W          = 32;
    localparam int ENTRY_W          = 16;
    localparam int DIM              = 4;
    localparam int CFG_IDX_W        = 3;
    localparam int CFG_DATA_W       = DIM * ENTRY_W;

    // datapath widths
    localparam int MAC_W   = ENTRY_W + COORD_W;          // one matrix product
    localparam int CLIP_W  = MAC_W + 2;                  // sum of four terms
    localparam int QUO_W   = COORD_W;                    // quotient bits kept
    localparam int DVD_W   = CLIP_W + COORD_FRAC_BITS;   // shifted dividend
    localparam int TOP_W   = DVD_W - QUO_W;              // dividend part above quotient
    localparam int NDC1_W  = COORD_W + 2;                // ndc plus one
    localparam int SCALE_W = ENTRY_W + 1 + NDC1_W;       // extent times (ndc plus one)
    localparam int SUM_W   = SCALE_W + 2;                // window coordinate before saturation

    // pipeline and queue
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);
    localparam int FRONT_LAT   = 2;
    localparam int DIV_LAT     = QUO_W + 3;
    localparam int POST_LAT    = 2;
    localparam int PIPE_LAT    = FRONT_LAT + 1 + DIV_LAT + POST_LAT;

    // fixed point constants
    localparam logic [ENTRY_W-1:0] MATRIX_UNIT = ENTRY_W'(1) << MATRIX_FRAC_BITS;
    localparam logic signed [NDC1_W-1:0] NDC_ONE = $signed(NDC1_W'(1) << COORD_FRAC_BITS);

    // register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_ROW0     = 3'd0,
        REG_ROW1     = 3'd1,
        REG_ROW2     = 3'd2,
        REG_ROW3     = 3'd3,
        REG_VIEWPORT = 3'd4
    } cfg_reg_t;

    // result status codes
    typedef enum logic [1:0] {
        STATUS_OK     = 2'd0,
        STATUS_IDENT  = 2'd1,
        STATUS_ZERO_W = 2'd2,
        STATUS_NEG_Z  = 2'd3
    } status_t;

    // [row][column] of signed entries, column 0 lowest
    typedef logic [DIM-1:0][DIM-1:0][ENTRY_W-1:0] matrix_t;

    typedef struct packed {
        logic [ENTRY_W-1:0] height;
        logic [ENTRY_W-1:0] width;
        logic [ENTRY_W-1:0] origin_y;
        logic [ENTRY_W-1:0] origin_x;
    } viewport_t;

    // word handed from front to back
    typedef struct packed {
        logic signed [CLIP_W-1:0] cx;
        logic signed [CLIP_W-1:0] cy;
        logic signed [CLIP_W-1:0] cz;
        logic signed [CLIP_W-1:0] cw;
        status_t                  status;
    } clip_word_t;

    // control riding alongside the divider pipeline
    typedef struct packed {
        logic    valid;
        status_t status;
    } tag_t;

endpackage

FILE: hw/rtl/vertex_projection_viewport_core.sv
// vertex_projection_viewport_core: top level with configuration registers
// depends on vpv_pkg, vpv_front, vpv_queue, vpv_back
`timescale 1ns / 1ps

// Projects one Q16.16 point per clock, while busy is low, to window x, y
// and depth. A point is taken when start is high and busy is low; its word
// comes out on done in order, held for exactly one cycle, and the receiver
// cannot stall it. On its way it passes the two-stage matrix transform,
// the hop through the front-to-back fifo and the three 32-stage quotient
// pipelines (one bit per stage) of the divide. Since the back end
// drains that fifo every cycle, busy stays low in normal use and a new
// point may be given on every clock. Registers are written over the cfg
// channel (always ready) and must only change while no point is in flight.
// Identity matrix, zero w and negative clip z are flagged in status with
// all coordinates forced to zero; other results saturate to 32 bits.

module vertex_projection_viewport_core (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 start,
    output logic                                 busy,
    input  logic signed [vpv_pkg::COORD_W-1:0]   point_x,
    input  logic signed [vpv_pkg::COORD_W-1:0]   point_y,
    input  logic signed [vpv_pkg::COORD_W-1:0]   point_z,
    output logic                                 done,
    output logic signed [vpv_pkg::COORD_W-1:0]   window_x,
    output logic signed [vpv_pkg::COORD_W-1:0]   window_y,
    output logic signed [vpv_pkg::COORD_W-1:0]   depth,
    output logic [1:0]                           status,
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [vpv_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [vpv_pkg::CFG_DATA_W-1:0]       cfg_data
);

    vpv_pkg::matrix_t    matrix_reg;
    vpv_pkg::viewport_t  viewport_reg;
    logic                front_valid;
    vpv_pkg::clip_word_t front_word;
    logic                queue_valid;
    vpv_pkg::clip_word_t queue_word;
    logic                almost_full;

    assign cfg_ready = 1'b1;
    assign busy      = almost_full;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            matrix_reg   <= '0;
            viewport_reg <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (vpv_pkg::cfg_reg_t'(cfg_index))
                vpv_pkg::REG_ROW0:     matrix_reg[0] <= cfg_data;
                vpv_pkg::REG_ROW1:     matrix_reg[1] <= cfg_data;
                vpv_pkg::REG_ROW2:     matrix_reg[2] <= cfg_data;
                vpv_pkg::REG_ROW3:     matrix_reg[3] <= cfg_data;
                vpv_pkg::REG_VIEWPORT: viewport_reg  <= cfg_data;
                default:               ;
            endcase
        end
    end

    // transform and classify
    vpv_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (start && !busy),
        .point_x   (point_x),
        .point_y   (point_y),
        .point_z   (point_z),
        .matrix    (matrix_reg),
        .out_valid (front_valid),
        .out_word  (front_word)
    );

    // decoupling fifo
    vpv_queue u_queue (
        .clk         (clk),
        .rst_n       (rst_n),
        .push        (front_valid),
        .push_word   (front_word),
        .rd_valid    (queue_valid),
        .rd_word     (queue_word),
        .almost_full (almost_full)
    );

    // divide and viewport map
    vpv_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (queue_valid),
        .in_word  (queue_word),
        .viewport (viewport_reg),
        .done     (done),
        .window_x (window_x),
        .window_y (window_y),
        .depth    (depth),
        .status   (status)
    );

endmodule

FILE: hw/rtl/vpv_front.sv
// vpv_front: matrix transform to clip space and status classification
// depends on vpv_pkg
`timescale 1ns / 1ps

module vpv_front (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    input  logic signed [vpv_pkg::COORD_W-1:0] point_x,
    input  logic signed [vpv_pkg::COORD_W-1:0] point_y,
    input  logic signed [vpv_pkg::COORD_W-1:0] point_z,
    input  vpv_pkg::matrix_t             matrix,
    output logic                         out_valid,
    output vpv_pkg::clip_word_t          out_word
);

    logic signed [vpv_pkg::COORD_W-1:0] pt [3];
    logic signed [vpv_pkg::MAC_W-1:0]   prod_next [vpv_pkg::DIM][3];
    logic signed [vpv_pkg::MAC_W-1:0]   prod_reg  [vpv_pkg::DIM][3];
    logic signed [vpv_pkg::CLIP_W-1:0]  bias_next [vpv_pkg::DIM];
    logic signed [vpv_pkg::CLIP_W-1:0]  bias_reg  [vpv_pkg::DIM];
    logic signed [vpv_pkg::CLIP_W-1:0]  clip_next [vpv_pkg::DIM];
    logic                               ident_next;
    logic                               ident_reg;
    logic                               s1_valid_reg;
    logic                               s2_valid_reg;
    vpv_pkg::status_t                   status_next;
    vpv_pkg::clip_word_t                word_next;
    vpv_pkg::clip_word_t                word_reg;

    assign pt[0] = point_x;
    assign pt[1] = point_y;
    assign pt[2] = point_z;

    // stage 1: twelve products, w column as a shift, identity check
    always_comb
    begin
        ident_next = 1'b1;
        for (int r = 0; r < vpv_pkg::DIM; r++)
        begin
            for (int c = 0; c < 3; c++)
            begin
                prod_next[r][c] = $signed(matrix[r][c]) * pt[c];
            end
            bias_next[r] = $signed(vpv_pkg::CLIP_W'($signed(matrix[r][3])))
                           <<< vpv_pkg::COORD_FRAC_BITS;
            for (int c = 0; c < vpv_pkg::DIM; c++)
            begin
                if (matrix[r][c] != ((r == c) ? vpv_pkg::MATRIX_UNIT : '0))
                begin
                    ident_next = 1'b0;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg  <= prod_next;
        bias_reg  <= bias_next;
        ident_reg <= ident_next;
    end

    // stage 2: row sums and classification
    always_comb
    begin
        for (int r = 0; r < vpv_pkg::DIM; r++)
        begin
            clip_next[r] = vpv_pkg::CLIP_W'(prod_reg[r][0])
                         + vpv_pkg::CLIP_W'(prod_reg[r][1])
                         + vpv_pkg::CLIP_W'(prod_reg[r][2])
                         + bias_reg[r];
        end
        priority if (ident_reg)
            status_next = vpv_pkg::STATUS_IDENT;
        else if (clip_next[3] == '0)
            status_next = vpv_pkg::STATUS_ZERO_W;
        else if (clip_next[2] < 0)
            status_next = vpv_pkg::STATUS_NEG_Z;
        else
            status_next = vpv_pkg::STATUS_OK;
        word_next.cx     = clip_next[0];
        word_next.cy     = clip_next[1];
        word_next.cz     = clip_next[2];
        word_next.cw     = clip_next[3];
        word_next.status = status_next;
    end

    always_ff @(posedge clk)
    begin
        word_reg <= word_next;
    end

    // valid pipeline
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= in_valid;
            s2_valid_reg <= s1_valid_reg;
        end
    end

    assign out_valid = s2_valid_reg;
    assign out_word  = word_reg;

endmodule

FILE: hw/rtl/vpv_queue.sv
// vpv_queue: short fifo of clip words between front and back
// depends on vpv_pkg
`timescale 1ns / 1ps

module vpv_queue (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  vpv_pkg::clip_word_t push_word,
    output logic                rd_valid,
    output vpv_pkg::clip_word_t rd_word,
    output logic                almost_full
);

    vpv_pkg::clip_word_t         mem_reg [vpv_pkg::QUEUE_DEPTH];
    logic [vpv_pkg::QPTR_W-1:0]  wr_ptr_reg;
    logic [vpv_pkg::QPTR_W-1:0]  rd_ptr_reg;
    logic [vpv_pkg::QCNT_W-1:0]  count_reg;
    logic [vpv_pkg::QCNT_W-1:0]  count_next;
    logic                        pop;

    // back side drains a word every cycle that the fifo holds one
    assign pop      = (count_reg != '0);
    assign rd_valid = pop;
    assign rd_word  = mem_reg[rd_ptr_reg];

    // room left for words already inside the front
    assign almost_full = (count_reg >=
                          vpv_pkg::QCNT_W'(vpv_pkg::QUEUE_DEPTH - vpv_pkg::FRONT_LAT));

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
            count_next = count_reg + 1'b1;
        else if (!push && pop)
            count_next = count_reg - 1'b1;
    end

    // storage
    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_ptr_reg] <= push_word;
    end

    // pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            count_reg <= count_next;
        end
    end

endmodule

FILE: hw/rtl/vpv_div.sv
// vpv_div: pipelined signed fixed point divider, one quotient bit per stage
// depends on vpv_pkg
`timescale 1ns / 1ps

module vpv_div (
    input  logic                               clk,
    input  logic signed [vpv_pkg::CLIP_W-1:0]  num,
    input  logic signed [vpv_pkg::CLIP_W-1:0]  den,
    output logic signed [vpv_pkg::COORD_W-1:0] quo
);

    logic [vpv_pkg::CLIP_W-1:0] n_abs;
    logic [vpv_pkg::CLIP_W-1:0] d_abs;
    logic [vpv_pkg::CLIP_W-1:0] n_p_reg;
    logic [vpv_pkg::CLIP_W-1:0] d_p_reg;
    logic                       neg_p_reg;

    logic [vpv_pkg::DVD_W-1:0]  dvd;
    logic [vpv_pkg::TOP_W-1:0]  top;
    logic [vpv_pkg::CLIP_W-1:0] top_ext;
    logic                       ovf0;

    logic [vpv_pkg::CLIP_W-1:0] rem_reg [vpv_pkg::QUO_W+1];
    logic [vpv_pkg::QUO_W-1:0]  lo_reg  [vpv_pkg::QUO_W+1];
    logic [vpv_pkg::QUO_W-1:0]  q_reg   [vpv_pkg::QUO_W+1];
    logic [vpv_pkg::CLIP_W-1:0] d_reg   [vpv_pkg::QUO_W+1];
    logic                       neg_reg [vpv_pkg::QUO_W+1];
    logic                       ovf_reg [vpv_pkg::QUO_W+1];

    logic [vpv_pkg::CLIP_W:0]   trial     [vpv_pkg::QUO_W];
    logic [vpv_pkg::CLIP_W:0]   diff      [vpv_pkg::QUO_W];
    logic [vpv_pkg::CLIP_W-1:0] step_rem  [vpv_pkg::QUO_W];
    logic                       step_bit  [vpv_pkg::QUO_W];

    logic [vpv_pkg::QUO_W-1:0]  q_fin;
    logic signed [vpv_pkg::COORD_W-1:0] quo_next;
    logic signed [vpv_pkg::COORD_W-1:0] quo_reg;

    // magnitudes and sign
    assign n_abs = num[vpv_pkg::CLIP_W-1] ? vpv_pkg::CLIP_W'(-num) : vpv_pkg::CLIP_W'(num);
    assign d_abs = den[vpv_pkg::CLIP_W-1] ? vpv_pkg::CLIP_W'(-den) : vpv_pkg::CLIP_W'(den);

    always_ff @(posedge clk)
    begin
        n_p_reg   <= n_abs;
        d_p_reg   <= d_abs;
        neg_p_reg <= num[vpv_pkg::CLIP_W-1] ^ den[vpv_pkg::CLIP_W-1];
    end

    // split shifted dividend, quotient beyond the kept bits saturates
    assign dvd     = {n_p_reg, {vpv_pkg::COORD_FRAC_BITS{1'b0}}};
    assign top     = dvd[vpv_pkg::DVD_W-1:vpv_pkg::QUO_W];
    assign top_ext = vpv_pkg::CLIP_W'(top);
    assign ovf0    = (top_ext >= d_p_reg);

    // restoring step per stage
    always_comb
    begin
        for (int k = 0; k < vpv_pkg::QUO_W; k++)
        begin
            trial[k] = {rem_reg[k], lo_reg[k][vpv_pkg::QUO_W-1]};
            diff[k]  = trial[k] - {1'b0, d_reg[k]};
            step_bit[k] = !diff[k][vpv_pkg::CLIP_W];
            step_rem[k] = step_bit[k] ? diff[k][vpv_pkg::CLIP_W-1:0]
                                      : trial[k][vpv_pkg::CLIP_W-1:0];
        end
    end

    // stage registers, entry stage first
    always_ff @(posedge clk)
    begin
        rem_reg[0] <= ovf0 ? '0 : top_ext;
        lo_reg[0]  <= dvd[vpv_pkg::QUO_W-1:0];
        q_reg[0]   <= '0;
        d_reg[0]   <= d_p_reg;
        neg_reg[0] <= neg_p_reg;
        ovf_reg[0] <= ovf0;
        for (int k = 0; k < vpv_pkg::QUO_W; k++)
        begin
            rem_reg[k+1] <= step_rem[k];
            lo_reg[k+1]  <= lo_reg[k] << 1;
            q_reg[k+1]   <= {q_reg[k][vpv_pkg::QUO_W-2:0], step_bit[k]};
            d_reg[k+1]   <= d_reg[k];
            neg_reg[k+1] <= neg_reg[k];
            ovf_reg[k+1] <= ovf_reg[k];
        end
    end

    // sign and saturation to the signed coordinate range
    assign q_fin = q_reg[vpv_pkg::QUO_W];

    always_comb
    begin
        if (!neg_reg[vpv_pkg::QUO_W])
        begin
            if (ovf_reg[vpv_pkg::QUO_W] || q_fin[vpv_pkg::QUO_W-1])
                quo_next = {1'b0, {(vpv_pkg::COORD_W-1){1'b1}}};
            else
                quo_next = $signed(q_fin);
        end
        else
        begin
            if (ovf_reg[vpv_pkg::QUO_W] ||
                (q_fin[vpv_pkg::QUO_W-1] && (q_fin[vpv_pkg::QUO_W-2:0] != '0)))
                quo_next = {1'b1, {(vpv_pkg::COORD_W-1){1'b0}}};
            else
                quo_next = $signed(-q_fin);
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
    end

    assign quo = quo_reg;

endmodule

FILE: hw/rtl/vpv_back.sv
// vpv_back: perspective divide, viewport mapping, saturation and result register
// depends on vpv_pkg and vpv_div
`timescale 1ns / 1ps

module vpv_back (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    input  vpv_pkg::clip_word_t                 in_word,
    input  vpv_pkg::viewport_t                  viewport,
    output logic                                done,
    output logic signed [vpv_pkg::COORD_W-1:0]  window_x,
    output logic signed [vpv_pkg::COORD_W-1:0]  window_y,
    output logic signed [vpv_pkg::COORD_W-1:0]  depth,
    output logic [1:0]                          status
);

    vpv_pkg::tag_t                       tag_reg [vpv_pkg::DIV_LAT];
    logic signed [vpv_pkg::COORD_W-1:0]  nx;
    logic signed [vpv_pkg::COORD_W-1:0]  ny;
    logic signed [vpv_pkg::COORD_W-1:0]  nz;
    logic signed [vpv_pkg::NDC1_W-1:0]   sx;
    logic signed [vpv_pkg::NDC1_W-1:0]   sy;
    logic signed [vpv_pkg::NDC1_W-1:0]   sz;

    logic signed [vpv_pkg::SCALE_W-1:0]  px_reg;
    logic signed [vpv_pkg::SCALE_W-1:0]  py_reg;
    logic signed [vpv_pkg::NDC1_W-1:0]   sz_reg;
    vpv_pkg::tag_t                       tag_a_reg;

    logic [vpv_pkg::SUM_W-1:0]           ox_term;
    logic [vpv_pkg::SUM_W-1:0]           oy_term;
    logic [vpv_pkg::SUM_W-1:0]           h_term;
    logic signed [vpv_pkg::SUM_W-1:0]    wx_full;
    logic signed [vpv_pkg::SUM_W-1:0]    wy_full;
    logic signed [vpv_pkg::SUM_W-1:0]    wz_full;
    logic                                ok;

    logic                                done_reg;
    logic signed [vpv_pkg::COORD_W-1:0]  window_x_reg;
    logic signed [vpv_pkg::COORD_W-1:0]  window_y_reg;
    logic signed [vpv_pkg::COORD_W-1:0]  depth_reg;
    logic [1:0]                          status_reg;

    // halving that truncates toward zero
    function automatic logic signed [vpv_pkg::SCALE_W-1:0] half_tz(
        input logic signed [vpv_pkg::SCALE_W-1:0] v
    );
        logic signed [vpv_pkg::SCALE_W-1:0] adj;
        adj = v + vpv_pkg::SCALE_W'(v[vpv_pkg::SCALE_W-1]);
        return adj >>> 1;
    endfunction

    // clamp to the signed coordinate range
    function automatic logic signed [vpv_pkg::COORD_W-1:0] sat_coord(
        input logic signed [vpv_pkg::SUM_W-1:0] v
    );
        logic [vpv_pkg::SUM_W-vpv_pkg::COORD_W:0] upper;
        upper = v[vpv_pkg::SUM_W-1:vpv_pkg::COORD_W-1];
        if ((&upper) || !(|upper))
            return v[vpv_pkg::COORD_W-1:0];
        else if (v[vpv_pkg::SUM_W-1])
            return {1'b1, {(vpv_pkg::COORD_W-1){1'b0}}};
        else
            return {1'b0, {(vpv_pkg::COORD_W-1){1'b1}}};
    endfunction

    // three dividers share one tag line
    vpv_div u_div_x (.clk(clk), .num(in_word.cx), .den(in_word.cw), .quo(nx));
    vpv_div u_div_y (.clk(clk), .num(in_word.cy), .den(in_word.cw), .quo(ny));
    vpv_div u_div_z (.clk(clk), .num(in_word.cz), .den(in_word.cw), .quo(nz));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < vpv_pkg::DIV_LAT; k++)
                tag_reg[k] <= '0;
        end
        else
        begin
            tag_reg[0].valid  <= in_valid;
            tag_reg[0].status <= in_word.status;
            for (int k = 1; k < vpv_pkg::DIV_LAT; k++)
                tag_reg[k] <= tag_reg[k-1];
        end
    end

    // ndc plus one, scaled by viewport extent
    assign sx = $signed({nx[vpv_pkg::COORD_W-1], nx[vpv_pkg::COORD_W-1], nx}) + vpv_pkg::NDC_ONE;
    assign sy = $signed({ny[vpv_pkg::COORD_W-1], ny[vpv_pkg::COORD_W-1], ny}) + vpv_pkg::NDC_ONE;
    assign sz = $signed({nz[vpv_pkg::COORD_W-1], nz[vpv_pkg::COORD_W-1], nz}) + vpv_pkg::NDC_ONE;

    always_ff @(posedge clk)
    begin
        px_reg <= $signed({1'b0, viewport.width}) * sx;
        py_reg <= $signed({1'b0, viewport.height}) * sy;
        sz_reg <= sz;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            tag_a_reg <= '0;
        else
            tag_a_reg <= tag_reg[vpv_pkg::DIV_LAT-1];
    end

    // window coordinates with y flipped against the height
    assign ox_term = vpv_pkg::SUM_W'(viewport.origin_x) << vpv_pkg::COORD_FRAC_BITS;
    assign oy_term = vpv_pkg::SUM_W'(viewport.origin_y) << vpv_pkg::COORD_FRAC_BITS;
    assign h_term  = vpv_pkg::SUM_W'(viewport.height) << vpv_pkg::COORD_FRAC_BITS;

    assign wx_full = $signed(ox_term) + vpv_pkg::SUM_W'(half_tz(px_reg));
    assign wy_full = $signed(h_term) - $signed(oy_term) - vpv_pkg::SUM_W'(half_tz(py_reg));
    assign wz_full = vpv_pkg::SUM_W'(half_tz(vpv_pkg::SCALE_W'(sz_reg)));
    assign ok      = (tag_a_reg.status == vpv_pkg::STATUS_OK);

    // result register, errors give zero coordinates
    always_ff @(posedge clk)
    begin
        window_x_reg <= ok ? sat_coord(wx_full) : '0;
        window_y_reg <= ok ? sat_coord(wy_full) : '0;
        depth_reg    <= ok ? sat_coord(wz_full) : '0;
        status_reg   <= tag_a_reg.status;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            done_reg <= 1'b0;
        else
            done_reg <= tag_a_reg.valid;
    end

    assign done     = done_reg;
    assign window_x = window_x_reg;
    assign window_y = window_y_reg;
    assign depth    = depth_reg;
    assign status   = status_reg;

endmodule

FILE: hw/rtl/vpv_checker.sv
// vpv_checker: port-level checks of the projection core, bound to the top level
// depends on vpv_pkg and vertex_projection_viewport_core
`timescale 1ns / 1ps

module vpv_checker (
    input logic                               clk,
    input logic                               rst_n,
    input logic                               start,
    input logic                               busy,
    input logic                               done,
    input logic signed [vpv_pkg::COORD_W-1:0] window_x,
    input logic signed [vpv_pkg::COORD_W-1:0] window_y,
    input logic signed [vpv_pkg::COORD_W-1:0] depth,
    input logic [1:0]                         status
);

    // an error word carries zero coordinates
    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        done && (status != vpv_pkg::STATUS_OK)
        |-> (window_x == '0) && (window_y == '0) && (depth == '0))
        else $error("error word with nonzero coordinates");

    // back end drains the fifo every cycle, so the front never backs up
    a_never_busy: assert property (@(posedge clk) disable iff (!rst_n)
        !busy)
        else $error("busy raised");

    // every result word goes back to a taken point at fixed latency
    a_done_latency: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start && !busy, vpv_pkg::PIPE_LAT))
        else $error("result word without a matching point");

endmodule

bind vertex_projection_viewport_core vpv_checker u_vpv_checker (.*);

FILE: sim/tb_top.sv
// tb_top: self-checking testbench of vertex_projection_viewport_core
// depends on vpv_pkg and the core; drives points and registers, checks every result word
`timescale 1ns / 1ps

module tb_top;

    localparam int  IDLE_LIMIT = 5000;
    localparam int  SETTLE     = vpv_pkg::PIPE_LAT + 10;
    localparam longint Q_ONE   = 64'sd1 << vpv_pkg::COORD_FRAC_BITS;
    localparam longint S32_HI  = 64'sd2147483647;
    localparam longint S32_LO  = -64'sd2147483648;

    typedef struct {
        logic signed [vpv_pkg::COORD_W-1:0] x;
        logic signed [vpv_pkg::COORD_W-1:0] y;
        logic signed [vpv_pkg::COORD_W-1:0] z;
    } point_t;

    typedef struct {
        logic signed [vpv_pkg::COORD_W-1:0] wx;
        logic signed [vpv_pkg::COORD_W-1:0] wy;
        logic signed [vpv_pkg::COORD_W-1:0] wz;
        vpv_pkg::status_t                   st;
    } window_t;

    logic clk;
    logic rst_n;
    logic start;
    logic busy;
    logic signed [vpv_pkg::COORD_W-1:0] point_x, point_y, point_z;
    logic done;
    logic signed [vpv_pkg::COORD_W-1:0] window_x, window_y, depth;
    logic [1:0] status;
    logic cfg_valid;
    logic cfg_ready;
    logic [vpv_pkg::CFG_IDX_W-1:0] cfg_index;
    logic [vpv_pkg::CFG_DATA_W-1:0] cfg_data;

    // testbench copy of the registers
    logic [vpv_pkg::CFG_DATA_W-1:0] mat_rows [vpv_pkg::DIM];
    logic [vpv_pkg::CFG_DATA_W-1:0] vp_rect;

    point_t  pending_points [$];
    window_t expected_windows [$];
    int      errors;
    int      idle_cycles;
    int      gap_left;
    int      burst_left;
    logic    took;

    vertex_projection_viewport_core dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .point_x   (point_x),
        .point_y   (point_y),
        .point_z   (point_z),
        .done      (done),
        .window_x  (window_x),
        .window_y  (window_y),
        .depth     (depth),
        .status    (status),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic longint sat32(input longint v);
        if (v > S32_HI)
            return S32_HI;
        if (v < S32_LO)
            return S32_LO;
        return v;
    endfunction

    // (num << frac) / den toward zero, quotient capped at 2^40, then saturated
    function automatic longint ndc_div(input longint num, input longint den);
        logic [127:0] n, d, q;
        logic neg;
        neg = (num < 0) != (den < 0);
        n = (num < 0) ? 128'(-num) : 128'(num);
        d = (den < 0) ? 128'(-den) : 128'(den);
        q = (n << vpv_pkg::COORD_FRAC_BITS) / d;
        if (q > (128'd1 << 40))
            q = 128'd1 << 40;
        return sat32(neg ? -longint'(q[63:0]) : longint'(q[63:0]));
    endfunction

    function automatic window_t project(input point_t pt);
        longint  p [vpv_pkg::DIM];
        longint  clip [vpv_pkg::DIM];
        longint  m, ox, oy, vw, vh, nx, ny, nz, yy;
        logic    ident;
        window_t res;
        p[0] = longint'(pt.x);
        p[1] = longint'(pt.y);
        p[2] = longint'(pt.z);
        p[3] = Q_ONE;
        ident = 1'b1;
        for (int r = 0; r < vpv_pkg::DIM; r++)
        begin
            clip[r] = 0;
            for (int c = 0; c < vpv_pkg::DIM; c++)
            begin
                m = longint'($signed(mat_rows[r][16*c +: 16]));
                if (m != ((r == c) ? longint'(vpv_pkg::MATRIX_UNIT) : 0))
                    ident = 1'b0;
                clip[r] += m * p[c];
            end
        end
        res.wx = '0;
        res.wy = '0;
        res.wz = '0;
        if (ident)
            res.st = vpv_pkg::STATUS_IDENT;
        else if (clip[3] == 0)
            res.st = vpv_pkg::STATUS_ZERO_W;
        else if (clip[2] < 0)
            res.st = vpv_pkg::STATUS_NEG_Z;
        else
        begin
            res.st = vpv_pkg::STATUS_OK;
            ox = longint'(vp_rect[15:0]);
            oy = longint'(vp_rect[31:16]);
            vw = longint'(vp_rect[47:32]);
            vh = longint'(vp_rect[63:48]);
            nx = ndc_div(clip[0], clip[3]);
            ny = ndc_div(clip[1], clip[3]);
            nz = ndc_div(clip[2], clip[3]);
            res.wx = vpv_pkg::COORD_W'(sat32(ox * Q_ONE + (vw * (nx + Q_ONE)) / 2));
            yy = oy * Q_ONE + (vh * (ny + Q_ONE)) / 2;
            res.wy = vpv_pkg::COORD_W'(sat32(vh * Q_ONE - yy));
            res.wz = vpv_pkg::COORD_W'(sat32((nz + Q_ONE) / 2));
        end
        return res;
    endfunction

    function automatic logic [vpv_pkg::CFG_DATA_W-1:0] pack_row(
        input logic [15:0] c0, input logic [15:0] c1,
        input logic [15:0] c2, input logic [15:0] c3);
        return {c3, c2, c1, c0};
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 95)
            return $urandom_range(4, 9);
        return $urandom_range(10, 40);
    endfunction

    // one register write over the cfg channel
    task automatic write_reg(input vpv_pkg::cfg_reg_t idx,
                             input logic [vpv_pkg::CFG_DATA_W-1:0] val);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic load_setup(input logic [vpv_pkg::CFG_DATA_W-1:0] r0,
                              input logic [vpv_pkg::CFG_DATA_W-1:0] r1,
                              input logic [vpv_pkg::CFG_DATA_W-1:0] r2,
                              input logic [vpv_pkg::CFG_DATA_W-1:0] r3,
                              input logic [vpv_pkg::CFG_DATA_W-1:0] vp);
        write_reg(vpv_pkg::REG_ROW0, r0);
        write_reg(vpv_pkg::REG_ROW1, r1);
        write_reg(vpv_pkg::REG_ROW2, r2);
        write_reg(vpv_pkg::REG_ROW3, r3);
        write_reg(vpv_pkg::REG_VIEWPORT, vp);
    endtask

    // wait until every point is sent and every word has come back
    task automatic drain();
        while (pending_points.size() != 0 || start || expected_windows.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic push_point(input logic [31:0] x, input logic [31:0] y, input logic [31:0] z);
        point_t pt;
        pt.x = x;
        pt.y = y;
        pt.z = z;
        pending_points.push_back(pt);
    endtask

    // mostly points in front of a perspective camera, some raw noise
    task automatic push_random_points(input int n);
        for (int i = 0; i < n; i++)
        begin
            if ($urandom_range(0, 99) < 60)
                push_point($signed($urandom_range(0, 20 << 16)) - (10 << 16),
                           $signed($urandom_range(0, 20 << 16)) - (10 << 16),
                           $signed($urandom_range(0, 16 << 16)) - (2 << 16));
            else
                push_point($urandom, $urandom, $urandom);
        end
    endtask

    function automatic logic [15:0] jitter(input logic [15:0] base);
        return base + 16'($signed($urandom_range(0, 512)) - 256);
    endfunction

    // point feed: holds a word until taken, then random gaps
    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            start <= 1'b0;
        end
        else if (start && !took)
        begin
            start <= 1'b1;
        end
        else if (gap_left > 0)
        begin
            start <= 1'b0;
            gap_left <= gap_left - 1;
        end
        else if (pending_points.size() != 0)
        begin
            start   <= 1'b1;
            point_x <= pending_points[0].x;
            point_y <= pending_points[0].y;
            point_z <= pending_points[0].z;
            void'(pending_points.pop_front());
            if (burst_left > 0)
            begin
                burst_left <= burst_left - 1;
                gap_left <= 0;
            end
            else
            begin
                gap_left <= pick_gap();
                if ($urandom_range(0, 99) < 2)
                    burst_left <= $urandom_range(20, 60);
            end
        end
        else
        begin
            start <= 1'b0;
        end
    end

    // result check, register copy and watchdog
    always @(posedge clk)
    begin
        window_t want;
        point_t  pt;
        took <= start && !busy;
        if (rst_n)
        begin
            idle_cycles <= idle_cycles + 1;
            if (cfg_valid && cfg_ready)
            begin
                idle_cycles <= 0;
                if (cfg_index < vpv_pkg::DIM)
                    mat_rows[cfg_index[1:0]] = cfg_data;
                else if (cfg_index == vpv_pkg::REG_VIEWPORT)
                    vp_rect = cfg_data;
            end
            if (start && !busy)
            begin
                idle_cycles <= 0;
                pt.x = point_x;
                pt.y = point_y;
                pt.z = point_z;
                expected_windows.push_back(project(pt));
            end
            if (done)
            begin
                idle_cycles <= 0;
                if (expected_windows.size() == 0)
                begin
                    $error("result word with nothing expected");
                    errors++;
                end
                else
                begin
                    want = expected_windows.pop_front();
                    if (window_x !== want.wx)
                    begin
                        $error("window_x expected %0d actual %0d", want.wx, window_x);
                        errors++;
                    end
                    if (window_y !== want.wy)
                    begin
                        $error("window_y expected %0d actual %0d", want.wy, window_y);
                        errors++;
                    end
                    if (depth !== want.wz)
                    begin
                        $error("depth expected %0d actual %0d", want.wz, depth);
                        errors++;
                    end
                    if (status !== want.st)
                    begin
                        $error("status expected %0d actual %0d", want.st, status);
                        errors++;
                    end
                end
            end
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("FAIL");
                $finish;
            end
        end
    end

    initial
    begin
        logic [15:0] u, z0;
        u  = vpv_pkg::MATRIX_UNIT;
        z0 = 16'h0000;
        rst_n       = 1'b0;
        start       = 1'b0;
        point_x     = '0;
        point_y     = '0;
        point_z     = '0;
        cfg_valid   = 1'b0;
        cfg_index   = '0;
        cfg_data    = '0;
        took        = 1'b0;
        errors      = 0;
        idle_cycles = 0;
        gap_left    = 0;
        burst_left  = 0;
        for (int r = 0; r < vpv_pkg::DIM; r++)
            mat_rows[r] = '0;
        vp_rect = '0;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // reset registers: zero matrix gives zero w
        push_point(32'h0001_0000, 32'h0002_0000, 32'h0003_0000);
        drain();

        // identity matrix
        load_setup(pack_row(u, z0, z0, z0), pack_row(z0, u, z0, z0),
                   pack_row(z0, z0, u, z0), pack_row(z0, z0, z0, u),
                   {16'd480, 16'd640, 16'd0, 16'd0});
        push_point(32'h7fff_ffff, 32'h8000_0000, 32'h0001_0000);
        push_point(32'h0, 32'h0, 32'h0);
        drain();

        // perspective camera: w = z, clip z = z + 1
        load_setup(pack_row(u, z0, z0, z0), pack_row(z0, u, z0, z0),
                   pack_row(z0, z0, u, u), pack_row(z0, z0, u, z0),
                   {16'd480, 16'd640, 16'd0, 16'd0});
        push_point(32'h0000_8000, 32'hffff_8000, 32'h0002_0000);
        push_point(32'h0, 32'h0, 32'h0);
        push_point(32'h0001_0000, 32'h0001_0000, 32'hfff0_0000);
        push_point(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff);
        push_point(32'h8000_0000, 32'h8000_0000, 32'h0000_0001);
        push_point(32'h7fff_ffff, 32'h8000_0000, 32'h0000_0100);
        push_point(32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff);
        push_point(32'h0, 32'h0, 32'hffff_0000);
        drain();

        // extreme entries and full viewport
        load_setup({4{16'h7fff}}, {4{16'h8000}}, {4{16'h7fff}}, {16'h0001, {3{16'h8000}}},
                   {64{1'b1}});
        push_point(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff);
        push_point(32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
        push_point(32'h0, 32'h0, 32'h0);
        push_point(32'h0000_0001, 32'h0, 32'h0);
        push_point(32'h5555_5555, 32'haaaa_aaaa, 32'h0f0f_0f0f);
        drain();

        // random settings
        for (int ph = 0; ph < 10; ph++)
        begin
            if (ph % 3 == 2)
                load_setup({$urandom, $urandom}, {$urandom, $urandom},
                           {$urandom, $urandom}, {$urandom, $urandom},
                           {$urandom, $urandom});
            else
                load_setup(pack_row(jitter(u), jitter(z0), jitter(z0), jitter(z0)),
                           pack_row(jitter(z0), jitter(u), jitter(z0), jitter(z0)),
                           pack_row(jitter(z0), jitter(z0), jitter(u), jitter(u)),
                           pack_row(jitter(z0), jitter(z0), jitter(u), jitter(z0)),
                           {16'($urandom_range(1, 2048)), 16'($urandom_range(1, 4096)),
                            16'($urandom_range(0, 512)), 16'($urandom_range(0, 512))});
            push_random_points(108);
            drain();
        end

        if (errors == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
